@@ rtl/vrd_pkg.sv @@
// vrd_pkg: types, widths and constant tables shared by the vector rotation core.
// Depends on nothing; imported by every module under rtl/.
package vrd_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 18;
  localparam int GUARD_BITS    = 8;
  localparam int TABLE_LEN     = 30;
  localparam int STG_W         = $clog2(TABLE_LEN);

  // datapath: Q(FRAC_BITS+GUARD_BITS) components, headroom for sqrt(2) growth
  localparam int CW = 32 + GUARD_BITS + 3;
  localparam int ZW = 33;

  // gain product is Q30 times the input, brought down to the guarded format
  localparam int GAIN_SH = 30 - GUARD_BITS;

  // angle reduction: turn = floor((a * 2^(32-F) + 180) / 360) mod 2^32,
  // with 360 = 8 * 45 so the /8 is exact and leaves a divide by 45
  localparam int NRES      = 45;
  localparam int ROUND8    = 180 / 8;
  localparam int ANG_SHIFT = 29 - FRAC_BITS;
  localparam int RES_W     = $clog2(2 * NRES);
  localparam int RU_W      = $clog2(NRES);
  localparam int RECIP_SH  = 37;
  localparam int QW        = 64 - RECIP_SH;
  localparam logic [31:0] RECIP45 = 32'((64'd1 << RECIP_SH) / NRES);
  // the +2^31 offset that makes the angle unsigned, split into quotient and rest
  localparam logic [31:0] BIAS_Q = 32'((64'd1 << 31) / NRES);
  localparam int          BIAS_R = int'((64'd1 << 31) % NRES);

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] angle_deg;
  } vrd_in_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
  } vrd_out_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } vrd_rot_t;

  typedef logic [NRES-1:0][31:0] frac_tbl_t;

  // atan(2^-i) in binary-angle units (2^32 = one turn)
  function automatic logic [31:0] atan_turn(input logic [STG_W-1:0] idx);
    logic [31:0] t;
    case (idx)
      0:       t = 32'd536870912;
      1:       t = 32'd316933406;
      2:       t = 32'd167458907;
      3:       t = 32'd85004756;
      4:       t = 32'd42667331;
      5:       t = 32'd21354465;
      6:       t = 32'd10679838;
      7:       t = 32'd5340245;
      8:       t = 32'd2670163;
      9:       t = 32'd1335087;
      10:      t = 32'd667544;
      11:      t = 32'd333772;
      12:      t = 32'd166886;
      13:      t = 32'd83443;
      14:      t = 32'd41722;
      15:      t = 32'd20861;
      16:      t = 32'd10430;
      17:      t = 32'd5215;
      18:      t = 32'd2608;
      19:      t = 32'd1304;
      20:      t = 32'd652;
      21:      t = 32'd326;
      22:      t = 32'd163;
      23:      t = 32'd81;
      24:      t = 32'd41;
      25:      t = 32'd20;
      26:      t = 32'd10;
      27:      t = 32'd5;
      28:      t = 32'd3;
      29:      t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = n;
    res = 64'd0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // restoring long division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = 64'd0;
    rem = 65'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // 1/sqrt(prod(1 + 4^-i)) in Q30, elaboration only
  function automatic logic [63:0] gain_q30();
    logic [63:0] p;
    logic [63:0] s;
    p = 64'd1 << 60;
    for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
      p = p + (p >> (2 * i));
    end
    s = isqrt64(p);
    if (s == 64'd0) begin
      s = 64'd1;
    end
    return udiv64((64'd1 << 60) + (s >> 1), s);
  endfunction

  // floor((r * 2^ANG_SHIFT + 22) / 45) for each remainder r
  function automatic frac_tbl_t make_frac_tbl();
    frac_tbl_t t;
    for (int r = 0; r < NRES; r++) begin
      t[r] = 32'(udiv64((64'(r) << ANG_SHIFT) + 64'(ROUND8), 64'(NRES)));
    end
    return t;
  endfunction

  localparam logic signed [63:0] GAIN     = signed'(gain_q30());
  localparam frac_tbl_t          FRAC_TBL = make_frac_tbl();

endpackage

@@ rtl/vrd_front.sv @@
// vrd_front: angle reduction to a binary angle, gain scaling and quadrant fold.
// Five register stages with per-stage flow control; uses vrd_pkg.
module vrd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  vrd_pkg::vrd_in_t  item,
  output logic              rot_valid,
  input  logic              rot_ready,
  output vrd_pkg::vrd_rot_t rot
);
  import vrd_pkg::*;

  localparam logic signed [31:0] QTR     = 32'sh4000_0000;
  localparam logic signed [63:0] RND_POS = 64'sd1 <<< (GAIN_SH - 1);
  localparam logic signed [63:0] RND_NEG = RND_POS + 64'sd1;

  logic v1, v2, v3, v4;
  logic go1, go2, go3, go4, go5;

  logic [31:0]        ua;
  logic [63:0]        pa1;
  logic [31:0]        ua1;
  logic signed [63:0] px1, py1, px2, py2, px3, py3, px4, py4;

  logic [QW-1:0]      q0;
  logic [31:0]        r0_full;
  logic [QW-1:0]      q2;
  logic [RES_W-1:0]   r0_2;

  logic               corr;
  logic [QW-1:0]      qu3;
  logic [RU_W-1:0]    ru3;

  logic               lo;
  logic [31:0]        qa;
  logic [RES_W-1:0]   ra_full;
  logic [RU_W-1:0]    ra;
  logic [31:0]        turn4;

  logic signed [31:0] z;
  logic               fold;
  logic [31:0]        zf;
  logic signed [63:0] vx, vy;

  // a stage loads when it is empty or its contents move on
  assign go5        = !rot_valid || rot_ready;
  assign go4        = !v4 || go5;
  assign go3        = !v3 || go4;
  assign go2        = !v2 || go3;
  assign go1        = !v1 || go2;
  assign item_ready = go1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      rot_valid <= 1'b0;
    end else begin
      if (go1) v1 <= item_valid;
      if (go2) v2 <= v1;
      if (go3) v3 <= v2;
      if (go4) v4 <= v3;
      if (go5) rot_valid <= v4;
    end
  end

  // stage 1: reciprocal multiply for /45, gain multiplies
  assign ua = unsigned'(item.angle_deg) ^ 32'h8000_0000;

  always_ff @(posedge clk) begin
    if (go1) begin
      pa1 <= 64'(ua) * 64'(RECIP45);
      ua1 <= ua;
      px1 <= 64'(item.vec_x) * GAIN;
      py1 <= 64'(item.vec_y) * GAIN;
    end
  end

  // stage 2: quotient estimate, low by at most one
  assign q0      = pa1[63:RECIP_SH];
  assign r0_full = ua1 - 32'(q0) * 32'(NRES);

  always_ff @(posedge clk) begin
    if (go2) begin
      q2   <= q0;
      r0_2 <= RES_W'(r0_full);
      px2  <= px1;
      py2  <= py1;
    end
  end

  // stage 3: one correction step
  assign corr = r0_2 >= RES_W'(NRES);

  always_ff @(posedge clk) begin
    if (go3) begin
      qu3 <= q2 + QW'(corr);
      ru3 <= corr ? RU_W'(r0_2 - RES_W'(NRES)) : RU_W'(r0_2);
      px3 <= px2;
      py3 <= py2;
    end
  end

  // stage 4: remove the unsigned offset, then build the binary angle
  assign lo      = ru3 < RU_W'(BIAS_R);
  assign qa      = 32'(qu3) - BIAS_Q - 32'(lo);
  assign ra_full = lo ? RES_W'(ru3) + RES_W'(NRES - BIAS_R)
                      : RES_W'(ru3) - RES_W'(BIAS_R);
  assign ra      = RU_W'(ra_full);

  always_ff @(posedge clk) begin
    if (go4) begin
      turn4 <= (qa << ANG_SHIFT) + FRAC_TBL[ra];
      px4   <= px3;
      py4   <= py3;
    end
  end

  // stage 5: fold outside +-90 degrees; -p + r written as ~p + (r + 1)
  assign z    = signed'(turn4);
  assign fold = (z > QTR) || (z < -QTR);
  assign zf   = fold ? (turn4 ^ 32'h8000_0000) : turn4;
  assign vx   = (fold ? ~px4 : px4) + (fold ? RND_NEG : RND_POS);
  assign vy   = (fold ? ~py4 : py4) + (fold ? RND_NEG : RND_POS);

  always_ff @(posedge clk) begin
    if (go5) begin
      rot.x <= CW'(vx >>> GAIN_SH);
      rot.y <= CW'(vy >>> GAIN_SH);
      rot.z <= ZW'(signed'(zf));
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v2 |-> r0_2 < RES_W'(2 * NRES))
    else $error("reciprocal quotient estimate off by more than one");

  a_ru_bound: assert property (@(posedge clk) disable iff (rst)
    v3 |-> ru3 < RU_W'(NRES))
    else $error("remainder not reduced below 45");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    rot_valid |-> (rot.z <= ZW'(QTR)) && (rot.z >= -ZW'(QTR)))
    else $error("folded angle outside the convergence range");

endmodule

@@ rtl/vrd_cell.sv @@
// vrd_cell: one CORDIC micro-rotation, registered, with its own valid bit.
// Iteration index comes in on a tied port; uses vrd_pkg.
module vrd_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [vrd_pkg::STG_W-1:0]  stage,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  vrd_pkg::vrd_rot_t          up,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output vrd_pkg::vrd_rot_t          dn
);
  import vrd_pkg::*;

  logic               go;
  logic signed [CW-1:0] xi, yi, dx, dy;
  logic signed [ZW-1:0] zi, da;

  assign go       = !dn_valid || dn_ready;
  assign up_ready = go;

  assign xi = up.x;
  assign yi = up.y;
  assign zi = up.z;
  assign dx = yi >>> stage;
  assign dy = xi >>> stage;
  assign da = signed'(ZW'(atan_turn(stage)));

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (go) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (!zi[ZW-1]) begin
        dn.x <= xi - dx;
        dn.y <= yi + dy;
        dn.z <= zi - da;
      end else begin
        dn.x <= xi + dx;
        dn.y <= yi - dy;
        dn.z <= zi + da;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dn_valid && !dn_ready |=> dn_valid && $stable(dn))
    else $error("cell lost or altered a stalled item");

endmodule

@@ rtl/vrd_round.sv @@
// vrd_round: drops the guard bits with round-half-up and saturates to 32 bits.
// Holds the output register of the core; uses vrd_pkg.
module vrd_round (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  vrd_pkg::vrd_rot_t up,
  output logic              result_valid,
  input  logic              result_ready,
  output vrd_pkg::vrd_out_t result
);
  import vrd_pkg::*;

  localparam logic signed [CW-1:0] RND = CW'(1) <<< (GUARD_BITS - 1);

  logic                 go;
  logic signed [CW-1:0] rx, ry;

  function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
    logic signed [31:0] r;
    if ((&v[CW-1:31]) || !(|v[CW-1:31])) begin
      r = v[31:0];
    end else if (v[CW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  assign go       = !result_valid || result_ready;
  assign up_ready = go;
  assign rx       = (up.x + RND) >>> GUARD_BITS;
  assign ry       = (up.y + RND) >>> GUARD_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go) begin
      result_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      result.rot_x <= sat32(rx);
      result.rot_y <= sat32(ry);
    end
  end

endmodule

@@ rtl/vector_rotate_degrees_core.sv @@
// vector_rotate_degrees_core: top level, CORDIC vector rotation by degrees.
// Chains vrd_front, CORDIC_STAGES vrd_cell instances and vrd_round; uses vrd_pkg.
//
//   channel   signals                              payload
//   item      item_valid / item_ready / item       vrd_in_t  (vec_x, vec_y, angle_deg)
//   result    result_valid / result_ready / result vrd_out_t (rot_x, rot_y)
//
// One item per cycle sustained while result_ready is high; the pipeline is built from
// the five front stages, one cell per micro-rotation and the output register.
// Every stage has its own valid bit, so empty stages fill even while result is stalled.
// Synchronous reset clears the valid bits only; no clearing pass.
module vector_rotate_degrees_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  vrd_pkg::vrd_in_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output vrd_pkg::vrd_out_t result
);
  import vrd_pkg::*;

  logic     chain_valid [CORDIC_STAGES+1];
  logic     chain_ready [CORDIC_STAGES+1];
  vrd_rot_t chain_data  [CORDIC_STAGES+1];

  vrd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .rot_valid  (chain_valid[0]),
    .rot_ready  (chain_ready[0]),
    .rot        (chain_data[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    vrd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .stage    (STG_W'(i)),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up       (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn       (chain_data[i+1])
    );
  end

  vrd_round u_round (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (chain_valid[CORDIC_STAGES]),
    .up_ready     (chain_ready[CORDIC_STAGES]),
    .up           (chain_data[CORDIC_STAGES]),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
